>>> rtl/cvsp_pkg.sv
// shared types and constants of the cube vertex source panner
`timescale 1ns / 1ps
package cvsp_pkg;

   localparam int MAX_POINTS  = 8;
   localparam int IDX_BITS    = 3;
   localparam int QUEUE_DEPTH = 4;

   // input format codes
   localparam logic [3:0] FMT_MONO   = 4'd0;
   localparam logic [3:0] FMT_STEREO = 4'd1;
   localparam logic [3:0] FMT_QUAD   = 4'd2;
   localparam logic [3:0] FMT_LCRS   = 4'd3;
   localparam logic [3:0] FMT_AFMT   = 4'd4;
   localparam logic [3:0] FMT_ACN    = 4'd5;
   localparam logic [3:0] FMT_FUMA   = 4'd6;
   localparam logic [3:0] FMT_CUBOID = 4'd7;
   localparam logic [3:0] FMT_LCR    = 4'd8;

   // register indexes
   localparam logic [2:0] REG_FORMAT = 3'd0;
   localparam logic [2:0] REG_LAYOUT = 3'd1;
   localparam logic [2:0] REG_ISO    = 3'd2;
   localparam logic [2:0] REG_ORBIT  = 3'd3;
   localparam logic [2:0] REG_SPREAD = 3'd4;

   typedef logic signed [17:0] coord_type;

   typedef struct packed {
      logic [3:0]  fmt;
      logic        hz;
      logic        iso;
      logic        ao;
      logic [14:0] spread;
   } cfg_type;

   typedef struct packed {
      logic [IDX_BITS-1:0] idx;
      logic                last;
      logic                hz;
      coord_type           x;
      coord_type           y;
      coord_type           z;
   } point_type;

endpackage

>>> rtl/cvsp_sincos.sv
// iterative quadrant sine and cosine unit, series evaluated in q30
`timescale 1ns / 1ps
module cvsp_sincos (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [15:0]         phase,
   output logic                done,
   output cvsp_pkg::coord_type sin_q,
   output cvsp_pkg::coord_type cos_q
);
   import cvsp_pkg::*;

   localparam logic [31:0] KS1 = 32'd1686629713;
   localparam logic [31:0] KS3 = 32'd693598668;
   localparam logic [31:0] KS5 = 32'd85569306;
   localparam logic [31:0] KS7 = 32'd5026995;
   localparam logic [31:0] KC2 = 32'd1324675879;
   localparam logic [31:0] KC4 = 32'd272375562;
   localparam logic [31:0] KC6 = 32'd22401990;
   localparam logic [31:0] KC8 = 32'd987048;
   localparam logic [31:0] ONE30 = 32'd1073741824;

   localparam logic [2:0] STEP_SQ   = 3'd0;
   localparam logic [2:0] STEP_A    = 3'd1;
   localparam logic [2:0] STEP_B    = 3'd2;
   localparam logic [2:0] STEP_C    = 3'd3;
   localparam logic [2:0] STEP_LAST = 3'd4;

   logic        busy_ff, busy_in;
   logic [2:0]  step_ff, step_in;
   logic [1:0]  quad_ff;
   logic [29:0] t_ff, t2_ff;
   logic [31:0] sa_ff, ca_ff;
   logic        done_ff, done_in;
   coord_type   sin_ff, cos_ff;

   logic [31:0] opa1, opa2, opb2, sh_a, sh_b, ks, kc, cm;
   logic [63:0] mul_a, mul_b;
   logic [16:0] qs, qc;
   coord_type   s_val, c_val;

   function automatic logic [16:0] to_q15(input logic [31:0] v);
      logic [32:0] s;
      s = ({1'b0, v} + 33'd16384) >> 15;
      return (s > 33'd32768) ? 17'd32768 : s[16:0];
   endfunction

   always_comb begin
      opa1 = (step_ff == STEP_SQ || step_ff == STEP_LAST) ? {2'b0, t_ff} : {2'b0, t2_ff};
      opa2 = (step_ff == STEP_SQ) ? {2'b0, t_ff} : ((step_ff == STEP_A) ? KS7 : sa_ff);
      opb2 = (step_ff == STEP_A) ? KC8 : ca_ff;
      mul_a = opa1 * opa2;
      mul_b = {32'b0, 2'b0, t2_ff} * {32'b0, opb2};
      sh_a = mul_a[61:30];
      sh_b = mul_b[61:30];
      case (step_ff)
         STEP_A:  begin ks = KS5; kc = KC6; end
         STEP_B:  begin ks = KS3; kc = KC4; end
         default: begin ks = KS1; kc = KC2; end
      endcase
      cm = (sh_b >= ONE30) ? 32'd0 : ONE30 - sh_b;
      qs = to_q15(sh_a);
      qc = to_q15(cm);
      // fold back out of the first quadrant
      case (quad_ff)
         2'd0:    begin s_val = coord_type'(qs);  c_val = coord_type'(qc);  end
         2'd1:    begin s_val = coord_type'(qc);  c_val = -coord_type'(qs); end
         2'd2:    begin s_val = -coord_type'(qs); c_val = -coord_type'(qc); end
         default: begin s_val = -coord_type'(qc); c_val = coord_type'(qs);  end
      endcase
      busy_in = busy_ff;
      step_in = step_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_SQ;
      end else if (busy_ff) begin
         step_in = step_ff + 3'd1;
         if (step_ff == STEP_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= STEP_SQ;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         t_ff    <= {phase[13:0], 16'b0};
         quad_ff <= phase[15:14];
      end else if (busy_ff) begin
         if (step_ff == STEP_SQ) begin
            t2_ff <= sh_a[29:0];
         end else if (step_ff == STEP_LAST) begin
            sin_ff <= s_val;
            cos_ff <= c_val;
         end else begin
            sa_ff <= ks - sh_a;
            ca_ff <= kc - sh_b;
         end
      end
   end

   assign done  = done_ff;
   assign sin_q = sin_ff;
   assign cos_q = cos_ff;

endmodule

>>> rtl/cvsp_front.sv
// front end: takes positions, places the virtual points and queues them
`timescale 1ns / 1ps
module cvsp_front (
   input  logic                clock,
   input  logic                reset,
   input  cvsp_pkg::cfg_type   cfg,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [63:0]         req_tdata,
   output logic                q_push,
   output cvsp_pkg::point_type q_point,
   input  logic                q_full
);
   import cvsp_pkg::*;

   localparam logic [15:0] EIGHTH = 16'd8192;
   localparam logic [15:0] QTURN  = 16'd16384;
   localparam logic [15:0] HTURN  = 16'd32768;
   localparam logic [15:0] TQTURN = 16'd49152;
   localparam coord_type   ROOT2  = 18'sd46341;
   localparam coord_type   HALF   = 18'sd32768;

   typedef enum logic [3:0] {
      F_IDLE = 4'b0001,
      F_TRIG = 4'b0010,
      F_WAIT = 4'b0100,
      F_EMIT = 4'b1000
   } fstate_type;

   fstate_type  state_ff, state_in;
   logic        hold_v_ff, hold_v_in;
   logic [63:0] hold_ff;
   logic [15:0] az_ff, orb_ff;
   coord_type   e_ff, d_ff, nd_ff;
   logic [3:0]  fmt_ff;
   logic        hz_ff, iso_ff, ao_ff;
   logic [14:0] sp_ff;
   logic [2:0]  jc_ff, jc_in, pi_ff, pi_in;
   logic [1:0]  ec_ff, ec_in;
   coord_type   mx_ff, my_ff, mz_ff, sx_ff, sz_ff, bx_ff, bz_ff;

   logic        start, sc_done, special, last_job, job_done;
   logic [3:0]  nj;
   logic [15:0] ang, ph0, ph1;
   coord_type   rad, sin_v, cos_v, d_in, ye, yd, ynd, midx, midz;
   coord_type   ma1, mb1, ma3, mb3, px, py, pz;
   coord_type   e_ph0, e_ph1;
   logic [1:0]  emit_cnt;

   function automatic coord_type mq(input coord_type a, input coord_type b);
      logic signed [35:0] p;
      logic [35:0]        m;
      p = a * b;
      m = p[35] ? 36'(-p) : 36'(p);
      m = (m + 36'd16384) >> 15;
      return p[35] ? -coord_type'(m[17:0]) : coord_type'(m[17:0]);
   endfunction

   // halves truncated toward zero
   function automatic coord_type half_tz(input coord_type a, input coord_type b);
      logic signed [18:0] s;
      s = 19'(a) + 19'(b);
      if (s < 0) s = s + 19'sd1;
      s = s >>> 1;
      return s[17:0];
   endfunction

   cvsp_sincos u_sincos (
      .clock (clock),
      .reset (reset),
      .start (state_ff == F_TRIG),
      .phase (ang),
      .done  (sc_done),
      .sin_q (sin_v),
      .cos_q (cos_v)
   );

   assign req_tready = !hold_v_ff;
   assign start      = (state_ff == F_IDLE) && hold_v_ff;
   assign d_in       = coord_type'($signed(hold_ff[47:32]));

   always_comb begin
      e_ph0 = HALF - e_ff;
      e_ph1 = HALF + e_ff;
      ph0 = e_ph0[16:1];
      ph1 = e_ph1[16:1];
      ye  = hz_ff ? '0 : e_ff;
      yd  = hz_ff ? '0 : d_ff;
      ynd = hz_ff ? '0 : -d_ff;
      midx = half_tz(sx_ff, mx_ff);
      midz = half_tz(sz_ff, mz_ff);
      special = (jc_ff == 3'd1) && (fmt_ff == FMT_MONO || fmt_ff == FMT_STEREO);
      rad = nd_ff;
      ang = az_ff;
      nj  = 4'd1;
      unique case (fmt_ff) inside
         FMT_MONO: begin
            nj  = (iso_ff && !hz_ff) ? 4'd2 : 4'd1;
            ang = (jc_ff == 3'd0) ? az_ff : ph0;
         end
         FMT_STEREO: begin
            nj = 4'd3;
            if (jc_ff == 3'd0) ang = az_ff;
            else if (jc_ff == 3'd1) ang = ph1;
            else begin
               ang = (ao_ff ? az_ff : orb_ff) + TQTURN;
               rad = coord_type'({3'b0, sp_ff});
            end
         end
         FMT_QUAD, FMT_CUBOID: begin
            nj  = (fmt_ff == FMT_QUAD) ? 4'd4 : 4'd8;
            ang = az_ff + EIGHTH + TQTURN + {jc_ff[1:0], 14'b0};
         end
         FMT_LCRS, FMT_LCR: begin
            nj  = 4'd2;
            ang = (jc_ff == 3'd0) ? az_ff - EIGHTH : az_ff + EIGHTH;
         end
         FMT_AFMT: begin
            nj  = 4'd4;
            rad = d_ff;
            case (jc_ff[1:0])
               2'd0:    ang = az_ff + EIGHTH + TQTURN;
               2'd1:    ang = az_ff + EIGHTH;
               2'd2:    ang = az_ff + EIGHTH + HTURN;
               default: ang = az_ff + EIGHTH + QTURN;
            endcase
         end
         FMT_ACN: begin
            nj  = 4'd7;
            rad = d_ff;
            case (jc_ff)
               3'd1:    ang = az_ff + QTURN;
               3'd4:    ang = az_ff + TQTURN;
               3'd6:    ang = az_ff + HTURN;
               default: ang = az_ff;
            endcase
         end
         FMT_FUMA: begin
            nj  = 4'd7;
            rad = d_ff;
            case (jc_ff)
               3'd2:    ang = az_ff + QTURN;
               3'd4:    ang = az_ff + HTURN;
               3'd5:    ang = az_ff + TQTURN;
               default: ang = az_ff;
            endcase
         end
         default: begin
            nj  = 4'd1;
            ang = az_ff;
         end
      endcase
      // multiplier operands: polar step, or scaling of a saved position
      ma1 = special ? sx_ff : cos_v;
      mb1 = special ? sin_v : rad;
      ma3 = special ? sz_ff : sin_v;
      mb3 = special ? sin_v : rad;
   end

   // points given by the finished step
   always_comb begin
      emit_cnt = 2'd1;
      px = mx_ff;
      py = ye;
      pz = mz_ff;
      unique case (fmt_ff) inside
         FMT_MONO: begin
            if (iso_ff && !hz_ff) begin
               emit_cnt = (jc_ff == 3'd1) ? 2'd1 : 2'd0;
               py = my_ff;
            end
         end
         FMT_STEREO: begin
            emit_cnt = (jc_ff == 3'd2) ? 2'd2 : 2'd0;
            px = (ec_ff == 2'd0) ? bx_ff + mx_ff : bx_ff - mx_ff;
            pz = (ec_ff == 2'd0) ? bz_ff + mz_ff : bz_ff - mz_ff;
         end
         FMT_LCRS, FMT_LCR: begin
            if (jc_ff != 3'd0) begin
               emit_cnt = (fmt_ff == FMT_LCRS) ? 2'd3 : 2'd2;
               case (ec_ff)
                  2'd0:    begin px = midx;  pz = midz;  end
                  2'd1:    begin px = mx_ff; pz = mz_ff; end
                  default: begin px = -midx; py = -ye; pz = -midz; end
               endcase
            end
         end
         FMT_AFMT: py = (jc_ff == 3'd0 || jc_ff == 3'd3) ? yd : ynd;
         FMT_ACN: begin
            py = '0;
            if (jc_ff == 3'd0) begin px = '0; pz = '0; end
            else if (jc_ff == 3'd2) begin px = '0; py = yd; pz = '0; end
            else if (jc_ff == 3'd5) begin px = '0; py = ynd; pz = '0; end
         end
         FMT_FUMA: begin
            py = '0;
            if (jc_ff == 3'd0) begin px = '0; pz = '0; end
            else if (jc_ff == 3'd3) begin px = '0; py = yd; pz = '0; end
            else if (jc_ff == 3'd6) begin px = '0; py = ynd; pz = '0; end
         end
         FMT_CUBOID: py = jc_ff[2] ? ynd : yd;
         default: py = ye;
      endcase
   end

   always_comb begin
      last_job = ({1'b0, jc_ff} == nj - 4'd1);
      q_push   = (state_ff == F_EMIT) && ({1'b0, ec_ff} < {1'b0, emit_cnt}) && !q_full;
      job_done = (state_ff == F_EMIT) &&
                 ((emit_cnt == 2'd0) || (q_push && ec_ff == emit_cnt - 2'd1));
      q_point.idx  = pi_ff;
      q_point.last = last_job && (ec_ff == emit_cnt - 2'd1);
      q_point.hz   = hz_ff;
      q_point.x    = px;
      q_point.y    = py;
      q_point.z    = pz;

      hold_v_in = hold_v_ff;
      if (req_tvalid && req_tready) hold_v_in = 1'b1;
      else if (start) hold_v_in = 1'b0;

      state_in = state_ff;
      jc_in = jc_ff;
      ec_in = ec_ff;
      pi_in = pi_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (start) begin
               state_in = F_TRIG;
               jc_in = '0;
               pi_in = '0;
            end
         end
         F_TRIG: state_in = F_WAIT;
         F_WAIT: begin
            if (sc_done) begin
               state_in = F_EMIT;
               ec_in = '0;
            end
         end
         F_EMIT: begin
            if (q_push) begin
               ec_in = ec_ff + 2'd1;
               pi_in = pi_ff + 3'd1;
            end
            if (job_done) begin
               state_in = last_job ? F_IDLE : F_TRIG;
               jc_in = jc_ff + 3'd1;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= F_IDLE;
         hold_v_ff <= 1'b0;
         jc_ff     <= '0;
         ec_ff     <= '0;
         pi_ff     <= '0;
      end else begin
         state_ff  <= state_in;
         hold_v_ff <= hold_v_in;
         jc_ff     <= jc_in;
         ec_ff     <= ec_in;
         pi_ff     <= pi_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) hold_ff <= req_tdata;
      if (start) begin
         az_ff  <= hold_ff[15:0];
         e_ff   <= coord_type'($signed(hold_ff[31:16]));
         d_ff   <= d_in;
         orb_ff <= hold_ff[63:48];
         nd_ff  <= mq(d_in, ROOT2);
         fmt_ff <= (cfg.fmt > FMT_LCR) ? FMT_MONO : cfg.fmt;
         hz_ff  <= cfg.hz;
         iso_ff <= cfg.iso;
         ao_ff  <= cfg.ao;
         sp_ff  <= cfg.spread;
      end
      if (state_ff == F_WAIT && sc_done) begin
         mx_ff <= mq(ma1, mb1);
         my_ff <= mq(cos_v, nd_ff);
         mz_ff <= mq(ma3, mb3);
      end
      if (job_done) begin
         if (jc_ff == 3'd0) begin
            sx_ff <= mx_ff;
            sz_ff <= mz_ff;
         end
         if (jc_ff == 3'd1) begin
            bx_ff <= (iso_ff && !hz_ff) ? mx_ff : sx_ff;
            bz_ff <= (iso_ff && !hz_ff) ? mz_ff : sz_ff;
         end
      end
   end

endmodule

>>> rtl/cvsp_queue.sv
// short point queue between the front and back ends
`timescale 1ns / 1ps
module cvsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  cvsp_pkg::point_type push_point,
   output logic                full,
   input  logic                pop,
   output cvsp_pkg::point_type head,
   output logic                empty
);
   import cvsp_pkg::*;

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

   point_type           mem_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ff, rd_ff;
   logic [PTR_BITS:0]   cnt_ff;

   assign full  = (cnt_ff == (PTR_BITS+1)'(QUEUE_DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop) rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (PTR_BITS+1)'(push) - (PTR_BITS+1)'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_point;
   end

endmodule

>>> rtl/cvsp_back.sv
// back end: maps a point into the cube and forms its eight corner gains
`timescale 1ns / 1ps
module cvsp_back #(
   parameter int GAIN_BITS = 17
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   output logic                              q_pop,
   input  cvsp_pkg::point_type               q_point,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [7:0][GAIN_BITS-1:0]         rsp_gain,
   output logic [cvsp_pkg::IDX_BITS-1:0]     rsp_idx,
   output logic                              rsp_last
);
   import cvsp_pkg::*;

   localparam int SH = 49 - GAIN_BITS;
   localparam logic [16:0] ONE16 = 17'd65536;

   logic                adv;
   logic                v1_ff, v2_ff, v3_ff;
   logic [16:0]         x1_ff, y1_ff, z1_ff;
   logic                hz1_ff;
   logic [IDX_BITS-1:0] idx1_ff, idx2_ff, idx3_ff;
   logic                last1_ff, last2_ff, last3_ff;
   logic [33:0]         fxz2_ff [4];
   logic [16:0]         fy2_ff [2];
   logic [GAIN_BITS-1:0] gain3_ff [8];
   logic [GAIN_BITS-1:0] gain_in [8];
   logic [33:0]         fxz_in [4];

   function automatic logic [16:0] map16(input coord_type v);
      coord_type c;
      c = v;
      if (c > 18'sd32768) c = 18'sd32768;
      if (c < -18'sd32768) c = -18'sd32768;
      c = c + 18'sd32768;
      return c[16:0];
   endfunction

   assign adv   = !v3_ff || rsp_ready;
   assign q_pop = adv && q_valid;

   always_comb begin
      logic [16:0] fx, fz;
      logic [1:0]  jj;
      for (int j = 0; j < 4; j++) begin
         jj = 2'(j);
         fx = jj[1] ? ONE16 - x1_ff : x1_ff;
         fz = jj[0] ? z1_ff : ONE16 - z1_ff;
         fxz_in[j] = {17'b0, fx} * {17'b0, fz};
      end
   end

   always_comb begin
      logic [50:0] p;
      logic [51:0] r;
      logic [2:0]  kk;
      for (int k = 0; k < 8; k++) begin
         kk = 3'(k);
         p = {17'b0, fxz2_ff[kk[1:0]]} * {34'b0, fy2_ff[kk[2]]};
         r = {1'b0, p} + (52'd1 << (SH - 1));
         gain_in[k] = r[SH +: GAIN_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= q_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x1_ff    <= map16(q_point.x);
         y1_ff    <= map16(q_point.y);
         z1_ff    <= map16(q_point.z);
         hz1_ff   <= q_point.hz;
         idx1_ff  <= q_point.idx;
         last1_ff <= q_point.last;
         for (int j = 0; j < 4; j++) fxz2_ff[j] <= fxz_in[j];
         fy2_ff[0] <= hz1_ff ? ONE16 : y1_ff;
         fy2_ff[1] <= hz1_ff ? 17'd0 : ONE16 - y1_ff;
         idx2_ff  <= idx1_ff;
         last2_ff <= last1_ff;
         for (int k = 0; k < 8; k++) gain3_ff[k] <= gain_in[k];
         idx3_ff  <= idx2_ff;
         last3_ff <= last2_ff;
      end
   end

   always_comb begin
      for (int k = 0; k < 8; k++) rsp_gain[k] = gain3_ff[k];
   end

   assign rsp_valid = v3_ff;
   assign rsp_idx   = idx3_ff;
   assign rsp_last  = last3_ff;

endmodule

>>> rtl/cube_vertex_source_panner.sv
// top level of the cube vertex source panner
//
// usage: each item on the req_ channel is one source position
// (azimuth, elevation, diverge, orbit). the configured input format turns
// it into 1 to 8 virtual points, and for each point one item leaves on the
// rsp_ channel with the eight corner gains, the point index in tuser and
// tlast on the final point of that position.
// the csr_ channel writes the five registers; it is always ready and is
// only meant to be used while no position is in flight.
// timing: a one-item input buffer takes the next position while the front
// end works. the front end runs one sincos evaluation per point step
// (five multiply steps in the shared series unit), then pushes the
// points of that step into the queue. the back end gain pipeline registers
// the mapped coordinates, the corner factors and the gains, and takes one
// point per cycle unless a stalled receiver holds it.
// reset empties the input buffer, queue and pipeline and restores the
// register defaults (mono, cube layout, isotropic on, no orbit, no spread).
// when the receiver stalls, the gain pipeline holds, the 4-entry point
// queue fills, then the front end and finally req_tready stall.
`timescale 1ns / 1ps
module cube_vertex_source_panner #(
   parameter int GAIN_BITS = 17
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // azimuth_turns, elevation_level, diverge_level, orbit_turns
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [63:0]                             req_tdata,
   // gain_0 .. gain_7, zero padded to whole bytes
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [((8*GAIN_BITS+7)/8)*8-1:0]        rsp_tdata,
   // point_index
   output logic [cvsp_pkg::IDX_BITS-1:0]           rsp_tuser,
   output logic                                    rsp_tlast,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [2:0]                              csr_index,
   input  logic [14:0]                             csr_data
);
   import cvsp_pkg::*;

   localparam int TDATA_W = ((8*GAIN_BITS+7)/8)*8;

   cfg_type   cfg_ff;
   point_type f_point, q_head;
   logic      q_push, q_full, q_pop, q_empty;
   logic [7:0][GAIN_BITS-1:0] gain_bus;

   // configuration registers, writes beyond the list are dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fmt    <= FMT_MONO;
         cfg_ff.hz     <= 1'b0;
         cfg_ff.iso    <= 1'b1;
         cfg_ff.ao     <= 1'b0;
         cfg_ff.spread <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_FORMAT: cfg_ff.fmt    <= csr_data[3:0];
            REG_LAYOUT: cfg_ff.hz     <= !csr_data[0];
            REG_ISO:    cfg_ff.iso    <= csr_data[0];
            REG_ORBIT:  cfg_ff.ao     <= csr_data[0];
            REG_SPREAD: cfg_ff.spread <= csr_data;
            default: ;
         endcase
      end
   end

   // front end: input buffer, point placement, sincos sequencing
   cvsp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_push     (q_push),
      .q_point    (f_point),
      .q_full     (q_full)
   );

   // decouples point placement from gain generation
   cvsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_point (f_point),
      .full       (q_full),
      .pop        (q_pop),
      .head       (q_head),
      .empty      (q_empty)
   );

   // back end: clamp, map and three-factor corner products
   cvsp_back #(
      .GAIN_BITS (GAIN_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (!q_empty),
      .q_pop     (q_pop),
      .q_point   (q_head),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_gain  (gain_bus),
      .rsp_idx   (rsp_tuser),
      .rsp_last  (rsp_tlast)
   );

   assign rsp_tdata = TDATA_W'(gain_bus);

   // the front end never pushes into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("point pushed into full queue");

   // the back end never pops an empty queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("point popped from empty queue");

   // a stalled result item holds its valid and its data
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("result item changed while stalled");

endmodule

>>> tb/cube_vertex_source_panner_tb.sv
// testbench for the cube vertex source panner: predicted corner gains against the block
`timescale 1ns / 1ps
module cube_vertex_source_panner_tb;
   import cvsp_pkg::*;

   localparam int GAIN_BITS = 17;
   localparam int DW = ((8*GAIN_BITS+7)/8)*8;
   localparam int STALL_LIMIT = 20000;

   typedef struct {
      logic [2:0]  idx;
      logic [16:0] g[8];
      logic        last;
   } gain_set_type;

   // ---------------------------------------------------------------------
   // fixed point helpers for the gain predictor
   // ---------------------------------------------------------------------
   function automatic longint to_q15(longint unsigned v30);
      longint unsigned v;
      v = (v30 + (64'd1 << 14)) >> 15;
      return (v > 32768) ? 32768 : v;
   endfunction

   function automatic longint quarter_sin(int unsigned r);
      longint unsigned t, t2, a;
      t = longint'(r) << 16;
      t2 = (t * t) >> 30;
      a = 64'd85569306 - ((t2 * 64'd5026995) >> 30);
      a = 64'd693598668 - ((t2 * a) >> 30);
      a = 64'd1686629713 - ((t2 * a) >> 30);
      return to_q15((t * a) >> 30);
   endfunction

   function automatic longint quarter_cos(int unsigned r);
      longint unsigned t, t2, a, m;
      t = longint'(r) << 16;
      t2 = (t * t) >> 30;
      a = 64'd22401990 - ((t2 * 64'd987048) >> 30);
      a = 64'd272375562 - ((t2 * a) >> 30);
      a = 64'd1324675879 - ((t2 * a) >> 30);
      m = (t2 * a) >> 30;
      return to_q15(m >= 64'd1073741824 ? 0 : 64'd1073741824 - m);
   endfunction

   function automatic longint sin_turns(int unsigned p);
      int unsigned q, r;
      q = (p >> 14) & 3;
      r = p & 16'h3fff;
      case (q)
         0: return quarter_sin(r);
         1: return quarter_cos(r);
         2: return -quarter_sin(r);
         default: return -quarter_cos(r);
      endcase
   endfunction

   function automatic longint cos_turns(int unsigned p);
      return sin_turns((p + 16384) & 16'hffff);
   endfunction

   // q15 product, halves away from zero
   function automatic longint qmul(longint a, longint b);
      longint p;
      p = a * b;
      if (p >= 0) return (p + 16384) >>> 15;
      return -((-p + 16384) >>> 15);
   endfunction

   // ---------------------------------------------------------------------
   // scoreboard
   // ---------------------------------------------------------------------
   class gain_scoreboard;
      gain_set_type pending[$];
      int        errors;
      logic [3:0]  fmt;
      logic        hz, iso, ao;
      logic [14:0] spread;

      function void reset_regs();
         fmt = FMT_MONO; hz = 0; iso = 1; ao = 0; spread = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [14:0] val);
         case (idx)
            REG_FORMAT: fmt = val[3:0];
            REG_LAYOUT: hz = ~val[0];
            REG_ISO:    iso = val[0];
            REG_ORBIT:  ao = val[0];
            REG_SPREAD: spread = val;
            default: ;
         endcase
      endfunction

      function void place(ref longint px[8], ref longint py[8], ref longint pz[8],
                          input int i, input int unsigned ang, input longint rad,
                          input longint y);
         ang = ang & 16'hffff;
         px[i] = qmul(cos_turns(ang), rad);
         py[i] = y;
         pz[i] = qmul(sin_turns(ang), rad);
      endfunction

      function longint unsigned map_unit(longint v);
         if (v > 32768) v = 32768;
         if (v < -32768) v = -32768;
         return v + 32768;
      endfunction

      // works out the point gains for one source position
      function void note_position(logic [63:0] d);
         longint px[8], py[8], pz[8];
         longint e, dv, nd, cx, cz, sa, s, ox, oz, bx, by, bz;
         int unsigned az, orb, ph, rot;
         int n;
         logic [3:0] f;
         longint unsigned fx[2], fz[2], fy[2], prod;
         gain_set_type res;
         az = d[15:0];
         e = $signed(d[31:16]);
         dv = $signed(d[47:32]);
         orb = d[63:48];
         f = (fmt > FMT_LCR) ? FMT_MONO : fmt;
         nd = qmul(dv, 46341);
         cx = qmul(cos_turns(az), nd);
         cz = qmul(sin_turns(az), nd);
         n = 0;
         if (f == FMT_MONO) begin
            n = 1;
            if (hz) begin
               px[0] = cx; py[0] = 0; pz[0] = cz;
            end else if (iso) begin
               ph = (int'(32768 - e) >>> 1) & 16'hffff;
               sa = sin_turns(ph);
               px[0] = qmul(cx, sa); py[0] = qmul(cos_turns(ph), nd); pz[0] = qmul(cz, sa);
            end else begin
               px[0] = cx; py[0] = e; pz[0] = cz;
            end
         end else if (f == FMT_STEREO) begin
            rot = ((ao ? az : orb) + 49152) & 16'hffff;
            s = spread;
            ox = qmul(cos_turns(rot), s);
            oz = qmul(sin_turns(rot), s);
            if (hz) begin
               bx = cx; by = 0; bz = cz;
            end else if (iso) begin
               sa = sin_turns((int'(32768 + e) >>> 1) & 16'hffff);
               bx = qmul(cx, sa); by = e; bz = qmul(cz, sa);
            end else begin
               bx = cx; by = e; bz = cz;
            end
            n = 2;
            px[0] = bx + ox; py[0] = by; pz[0] = bz + oz;
            px[1] = bx - ox; py[1] = by; pz[1] = bz - oz;
         end else begin
            case (f)
               FMT_QUAD: begin
                  n = 4;
                  for (int i = 0; i < 4; i++)
                     place(px, py, pz, i, az + 8192 + 49152 + 16384*i, nd, e);
               end
               FMT_LCRS, FMT_LCR: begin
                  place(px, py, pz, 0, az + 65536 - 8192, nd, e);
                  place(px, py, pz, 2, az + 8192, nd, e);
                  // centre is the truncated midpoint of left and right
                  px[1] = (px[0] + px[2]) / 2;
                  py[1] = (py[0] + py[2]) / 2;
                  pz[1] = (pz[0] + pz[2]) / 2;
                  n = 3;
                  if (f == FMT_LCRS) begin
                     px[3] = -px[1]; py[3] = -py[1]; pz[3] = -pz[1]; n = 4;
                  end
               end
               FMT_AFMT: begin
                  n = 4;
                  place(px, py, pz, 0, az + 8192 + 49152, dv, dv);
                  place(px, py, pz, 1, az + 8192, dv, -dv);
                  place(px, py, pz, 2, az + 8192 + 32768, dv, -dv);
                  place(px, py, pz, 3, az + 8192 + 16384, dv, dv);
               end
               FMT_ACN: begin
                  n = 7;
                  px[0] = 0; py[0] = 0; pz[0] = 0;
                  place(px, py, pz, 1, az + 16384, dv, 0);
                  px[2] = 0; py[2] = dv; pz[2] = 0;
                  place(px, py, pz, 3, az, dv, 0);
                  place(px, py, pz, 4, az + 49152, dv, 0);
                  px[5] = 0; py[5] = -dv; pz[5] = 0;
                  place(px, py, pz, 6, az + 32768, dv, 0);
               end
               FMT_FUMA: begin
                  n = 7;
                  px[0] = 0; py[0] = 0; pz[0] = 0;
                  place(px, py, pz, 1, az, dv, 0);
                  place(px, py, pz, 2, az + 16384, dv, 0);
                  px[3] = 0; py[3] = dv; pz[3] = 0;
                  place(px, py, pz, 4, az + 32768, dv, 0);
                  place(px, py, pz, 5, az + 49152, dv, 0);
                  px[6] = 0; py[6] = -dv; pz[6] = 0;
               end
               default: begin
                  n = 8;
                  for (int i = 0; i < 4; i++) begin
                     place(px, py, pz, i, az + 8192 + 49152 + 16384*i, nd, dv);
                     place(px, py, pz, i + 4, az + 8192 + 49152 + 16384*i, nd, -dv);
                  end
               end
            endcase
            if (hz) for (int i = 0; i < n; i++) py[i] = 0;
         end
         for (int i = 0; i < n; i++) begin
            fx[0] = map_unit(px[i]); fx[1] = 65536 - fx[0];
            fz[1] = map_unit(pz[i]); fz[0] = 65536 - fz[1];
            fy[0] = hz ? 65536 : map_unit(py[i]);
            fy[1] = hz ? 0 : 65536 - map_unit(py[i]);
            res.idx = 3'(i);
            for (int k = 0; k < 8; k++) begin
               prod = fx[(k >> 1) & 1] * fz[k & 1] * fy[(k >> 2) & 1];
               res.g[k] = 17'((prod + (64'd1 << (49 - GAIN_BITS - 1))) >> (49 - GAIN_BITS));
            end
            res.last = (i == n - 1);
            pending = {pending, res};
         end
      endfunction

      function void check_point(logic [DW-1:0] d, logic [2:0] idx, logic last);
         gain_set_type x;
         if (pending.size() == 0) begin
            $error("unexpected point item idx=%0d", idx);
            errors++;
            return;
         end
         x = pending.pop_front();
         if (idx !== x.idx) begin
            $error("point_index expected %0d actual %0d", x.idx, idx); errors++;
         end
         for (int k = 0; k < 8; k++)
            if (d[k*GAIN_BITS +: GAIN_BITS] !== x.g[k]) begin
               $error("gain_%0d expected %0d actual %0d", k, x.g[k],
                      d[k*GAIN_BITS +: GAIN_BITS]);
               errors++;
            end
         if (last !== x.last) begin
            $error("last_point expected %0d actual %0d", x.last, last); errors++;
         end
      endfunction
   endclass

   // ---------------------------------------------------------------------
   // dut hookup
   // ---------------------------------------------------------------------
   logic          clock = 0, reset = 1;
   logic          req_tvalid = 0, req_tready;
   logic [63:0]   req_tdata = '0;
   logic          rsp_tvalid, rsp_tready = 0, rsp_tlast;
   logic [DW-1:0] rsp_tdata;
   logic [2:0]    rsp_tuser;
   logic          csr_valid = 0, csr_ready;
   logic [2:0]    csr_index = '0;
   logic [14:0]   csr_data = '0;

   cube_vertex_source_panner #(.GAIN_BITS(GAIN_BITS)) DUT (.*);

   initial forever #6 clock = ~clock;

   gain_scoreboard sb = new();
   int  idle_cycles;
   bit  hold_off;     // long receiver stall requested by the stimulus
   bit  rsp_random = 1;

   // watchdog: cycles with no handshake on the req or rsp channel
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // result checking at the rising edge
   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_point(rsp_tdata, rsp_tuser, rsp_tlast);

   // receiver: random stalls, plus one long hold-off
   initial begin
      int w;
      @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_tready <= 0;
            repeat (400) @(negedge clock);
            hold_off = 0;
         end
         w = rsp_random ? $urandom_range(0, 14) : 0;
         if ($urandom_range(0, 3) == 0) w = 0;
         if (w > 0) begin
            rsp_tready <= 0;
            repeat (w) @(negedge clock);
         end
         rsp_tready <= 1;
         @(negedge clock);
      end
   end

   task automatic send_position(logic [15:0] az, logic [15:0] el, logic [15:0] dv,
                                logic [15:0] orb, bit gaps);
      int w;
      w = gaps ? $urandom_range(0, 14) : 0;
      if (w > 0) begin
         req_tvalid <= 0;
         repeat (w) @(negedge clock);
      end
      req_tdata  <= {orb, dv, el, az};
      req_tvalid <= 1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_position({orb, dv, el, az});
      @(negedge clock);
   endtask

   task automatic send_random(bit gaps);
      logic [15:0] v[4];
      for (int i = 0; i < 4; i++) begin
         case ($urandom_range(0, 5))
            0: v[i] = 16'h0000;
            1: v[i] = 16'hffff;
            2: v[i] = 16'h8000;
            3: v[i] = 16'h7fff;
            default: v[i] = 16'($urandom);
         endcase
      end
      send_position(v[0], v[1], v[2], v[3], gaps);
   endtask

   // waits until every expected point has arrived, then lets the pipe drain
   task automatic drain();
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [14:0] val);
      csr_index <= idx;
      csr_data  <= val;
      csr_valid <= 1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_valid <= 0;
      @(negedge clock);
   endtask

   initial begin
      logic [3:0] f;
      sb.reset_regs();
      repeat (10) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed: field extremes in the reset setting
      send_position(16'h0000, 16'h0000, 16'h0000, 16'h0000, 0);
      send_position(16'hffff, 16'h7fff, 16'h7fff, 16'hffff, 0);
      send_position(16'h4000, 16'h8000, 16'h8000, 16'h0000, 0);
      send_position(16'h2000, 16'h8000, 16'h7fff, 16'h8000, 0);
      drain();

      // directed: every format, both layouts, saturating diverge
      for (int fm = 0; fm < 10; fm++) begin
         f = (fm == 9) ? 4'd15 : fm[3:0];  // unused code acts as mono
         write_reg(REG_FORMAT, {11'd0, f});
         write_reg(REG_LAYOUT, {14'd0, fm[0]});
         write_reg(REG_ISO, {14'd0, fm[1]});
         write_reg(REG_ORBIT, {14'd0, fm[2]});
         write_reg(REG_SPREAD, fm[0] ? 15'h7fff : 15'h0000);
         send_position(16'h1234, 16'h8000, 16'h7fff, 16'hc000, 0);
         send_position(16'hf000, 16'h7fff, 16'h8000, 16'h0001, 0);
         drain();
      end
      write_reg(3'd7, 15'h1);   // out of range index, ignored

      // long receiver hold-off while the sender keeps pushing
      hold_off = 1;
      for (int i = 0; i < 12; i++) send_random(0);
      drain();

      // random phases over register settings
      for (int ph = 0; ph < 22; ph++) begin
         write_reg(REG_FORMAT, {11'd0, 4'($urandom_range(0, 10))});
         write_reg(REG_LAYOUT, 15'($urandom_range(0, 1)));
         write_reg(REG_ISO, 15'($urandom_range(0, 1)));
         write_reg(REG_ORBIT, 15'($urandom_range(0, 1)));
         case ($urandom_range(0, 2))
            0: write_reg(REG_SPREAD, 15'h0);
            1: write_reg(REG_SPREAD, 15'h7fff);
            default: write_reg(REG_SPREAD, 15'($urandom));
         endcase
         rsp_random = (ph % 4 != 3);
         for (int i = 0; i < 20; i++) send_random(ph % 4 != 2);
         drain();
      end

      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule

>>> cube_vertex_source_panner.f
rtl/cvsp_pkg.sv
rtl/cvsp_sincos.sv
rtl/cvsp_front.sv
rtl/cvsp_queue.sv
rtl/cvsp_back.sv
rtl/cube_vertex_source_panner.sv
tb/cube_vertex_source_panner_tb.sv
